// ===== sv/assert_macros.svh =====
// Assertion macros used by the LFU cache policy module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/lfu_pkg.sv =====
// Shared constants for the LFU cache policy block.
package lfu_pkg;

  localparam int KEY_W     = 32;
  localparam int STAMP_W   = 32;
  localparam int CAP_W     = 7;
  localparam int CAP_RESET = 64;

endpackage

// ===== sv/lfu_if.sv =====
// Request and response channel interfaces of the LFU cache policy block.
interface lfu_req_if;
  logic                             valid;
  logic                             ready;
  logic signed [lfu_pkg::KEY_W-1:0] request_key;

  modport source (output valid, output request_key, input ready);
  modport sink (input valid, input request_key, output ready);
endinterface

interface lfu_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

// ===== sv/lfu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lfu_cache_policy.sv =====
// Top level of the LFU cache policy: slot scan, victim choice and write-back.
//
//   channel  | direction | handshake     | payload
//   in_req   | input     | valid / ready | request_key (32-bit signed)
//   out_rsp  | output    | valid / ready | hit (1 bit)
//   cfg      | input     | write enable  | capacity_in_use (7 bits)
//
// A request to an empty store is answered without a scan; otherwise the occupied slots
// are read in order through the one-entry-per-cycle read port of the slot RAM.
// A hit ends the scan at the matching slot.
// Synchronous reset empties the store at once; the occupancy count marks valid slots.
// A waiting response holds off the next request until it is taken.
module lfu_cache_policy #(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lfu_req_if.sink                     in_req,
  lfu_rsp_if.source                   out_rsp,
  input  logic                        cfg_wr_en,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_wr_data
);

`include "assert_macros.svh"

  localparam int ADDR_W  = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int OCC_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = OCC_W > lfu_pkg::CAP_W ? OCC_W : lfu_pkg::CAP_W;
  localparam int ENTRY_W = lfu_pkg::KEY_W + COUNT_BITS + lfu_pkg::STAMP_W;

  typedef struct packed {
    logic [lfu_pkg::KEY_W-1:0]   key;
    logic [COUNT_BITS-1:0]       count;
    logic [lfu_pkg::STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                      state_r;
  logic [lfu_pkg::CAP_W-1:0]   capacity_r;
  logic [OCC_W-1:0]            occupied_r;
  logic [lfu_pkg::STAMP_W-1:0] stamp_clock_r;
  logic [lfu_pkg::KEY_W-1:0]   key_r;
  logic [OCC_W-1:0]            issue_idx_r;
  logic                        pend_r;
  logic [ADDR_W-1:0]           pend_idx_r;
  logic                        first_r;
  logic [ADDR_W-1:0]           best_idx_r;
  logic [COUNT_BITS-1:0]       best_cnt_r;
  logic [lfu_pkg::STAMP_W-1:0] best_stamp_r;
  logic                        out_valid_r;
  logic                        out_hit_r;

  logic               in_accept;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  entry_t             cur;
  entry_t             wr_entry;
  logic               match;
  logic               better;
  logic               last;
  logic               done_scan;
  logic [ADDR_W-1:0]  victim_idx;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  assign in_req.ready  = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_accept     = in_req.valid && in_req.ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.hit   = out_hit_r;

  always_comb begin
    cap_eff = CMP_W'(capacity_r);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end
    if (cap_eff > CMP_W'(SLOTS)) begin
      cap_eff = CMP_W'(SLOTS);
    end
    full = CMP_W'(occupied_r) >= cap_eff;

    cur    = entry_t'(rd_data);
    match  = pend_r && (cur.key == key_r);
    better = first_r || (cur.count < best_cnt_r) ||
             ((cur.count == best_cnt_r) && (cur.stamp < best_stamp_r));
    last   = (OCC_W'(pend_idx_r) + OCC_W'(1)) == occupied_r;
    done_scan  = (state_r == ST_SCAN) && pend_r && (match || last);
    victim_idx = better ? pend_idx_r : best_idx_r;

    rd_en   = (state_r == ST_SCAN) && (issue_idx_r < occupied_r);
    rd_addr = issue_idx_r[ADDR_W-1:0];

    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_entry = '{key: key_r, count: COUNT_BITS'(1), stamp: stamp_clock_r};
    if (in_accept && (occupied_r == '0)) begin
      wr_en    = 1'b1;
      wr_entry = '{key: in_req.request_key, count: COUNT_BITS'(1),
                   stamp: stamp_clock_r + 1'b1};
    end else if (done_scan) begin
      wr_en = 1'b1;
      if (match) begin
        wr_addr        = pend_idx_r;
        wr_entry.count = (cur.count == '1) ? cur.count : cur.count + 1'b1;
      end else if (full) begin
        wr_addr = victim_idx;
      end else begin
        wr_addr = occupied_r[ADDR_W-1:0];
      end
    end
  end

  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      capacity_r    <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
      occupied_r    <= '0;
      stamp_clock_r <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
      first_r       <= 1'b1;
      issue_idx_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      if (out_valid_r && out_rsp.ready && !wr_en) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            stamp_clock_r <= stamp_clock_r + 1'b1;
            key_r         <= in_req.request_key;
            issue_idx_r   <= '0;
            pend_r        <= 1'b0;
            first_r       <= 1'b1;
            if (occupied_r == '0) begin
              occupied_r  <= OCC_W'(1);
              out_valid_r <= 1'b1;
              out_hit_r   <= 1'b0;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_r     <= rd_en && !done_scan;
          pend_idx_r <= rd_addr;
          if (rd_en) begin
            issue_idx_r <= issue_idx_r + 1'b1;
          end
          if (pend_r) begin
            first_r <= 1'b0;
            if (better) begin
              best_idx_r   <= pend_idx_r;
              best_cnt_r   <= cur.count;
              best_stamp_r <= cur.stamp;
            end
          end
          if (done_scan) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_hit_r   <= match;
            if (!match && !full) begin
              occupied_r <= occupied_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_occ_bound, occupied_r > OCC_W'(SLOTS), "occupancy exceeds slot count")
  `ASSERT_CLK(a_wr_done, wr_en |=> out_valid_r, "slot write without a response")
  `ASSERT_CLK(a_occ_inc, $past(rst_n) && (occupied_r != $past(occupied_r)) |-> occupied_r == $past(occupied_r) + 1'b1, "occupancy jump")
  `ASSERT_CLK(a_occ_miss, $past(rst_n) && (occupied_r != $past(occupied_r)) |-> out_valid_r && !out_hit_r, "occupancy grew without a miss")

endmodule

// ===== tb/sv/lfu_policy_checker.sv =====
// Checker that predicts and compares hit/miss responses of the LFU cache policy block.
`timescale 1ns / 100ps

module lfu_policy_checker #(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lfu_req_if                          req,
  lfu_rsp_if                          rsp,
  input  logic                        cfg_wr_en,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_wr_data,
  output int                          error_count,
  output int                          pending
);

  localparam logic [COUNT_BITS-1:0] USE_MAX = '1;

  typedef struct packed {
    logic [lfu_pkg::KEY_W-1:0] key;
    logic                      hit;
  } lookup_t;

  logic [lfu_pkg::KEY_W-1:0]   slot_tag [SLOTS];
  bit                          slot_live [SLOTS];
  logic [COUNT_BITS-1:0]       slot_uses [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] slot_when [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] now_stamp;
  int                          filled;
  logic [lfu_pkg::CAP_W-1:0]   capacity;
  lookup_t                     hit_expected_q [$];
  int                          shown;

  function automatic bit lfu_lookup(input logic [lfu_pkg::KEY_W-1:0] key);
    int limit;
    int pick;
    now_stamp = now_stamp + 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_tag[i] == key) begin
        if (slot_uses[i] != USE_MAX) slot_uses[i] = slot_uses[i] + 1'b1;
        slot_when[i] = now_stamp;
        return 1'b1;
      end
    end
    limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : int'(capacity));
    pick = -1;
    if (filled < limit) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_live[i] && pick < 0) pick = i;
      end
    end
    if (pick < 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && (pick < 0 || slot_uses[i] < slot_uses[pick] ||
            (slot_uses[i] == slot_uses[pick] && slot_when[i] < slot_when[pick]))) begin
          pick = i;
        end
      end
    end else begin
      filled++;
    end
    slot_tag[pick]  = key;
    slot_live[pick] = 1'b1;
    slot_uses[pick] = COUNT_BITS'(1);
    slot_when[pick] = now_stamp;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_tag[i]  = '0;
        slot_live[i] = 1'b0;
        slot_uses[i] = '0;
        slot_when[i] = '0;
      end
      now_stamp = '0;
      filled = 0;
      capacity = lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
      hit_expected_q.delete();
      shown = 0;
      error_count = 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (req.valid && req.ready) begin
        want.key = req.request_key;
        want.hit = lfu_lookup(req.request_key);
        hit_expected_q.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        if (hit_expected_q.size() == 0) begin
          error_count++;
          if (shown < 10) begin
            shown++;
            $display("%0t: response with hit %0d but no request outstanding",
                     $realtime, rsp.hit);
          end
        end else begin
          want = hit_expected_q.pop_front();
          if (rsp.hit !== want.hit) begin
            error_count++;
            if (shown < 10) begin
              shown++;
              $display("%0t: key %h: expected hit %0d, got %0d", $realtime, want.key,
                       want.hit, rsp.hit);
            end
          end
        end
      end
      pending <= hit_expected_q.size();
    end
  end

endmodule

// ===== tb/sv/lfu_cache_policy_test.sv =====
// Top of the LFU cache policy testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module lfu_cache_policy_test;

  localparam int POOL_SIZE    = 80;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 208;
  localparam int HOT_HITS     = 20;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 400;
  localparam int DRAIN_CYCLES = 80;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [lfu_pkg::CAP_W-1:0] cfg_wr_data;
  int                        errors;
  int                        pending;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  int                        random_sent;
  bit                        holdoff_done;
  logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int                        phase_caps [PHASES];

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  lfu_cache_policy uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_rsp     (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lfu_policy_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .error_count (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("lfu_cache_policy_test: errors");
    $finish;
  end

  task automatic send_request(input logic [lfu_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.request_key = key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_ch.valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [lfu_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom();
    if (r < 15) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if ($urandom_range(1) == 0) return key_pool[$urandom_range(7)];
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  initial begin
    rsp_ch.ready = 1'b0;
    holdoff_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!holdoff_done && random_sent >= HOLD_AT) begin
        holdoff_done = 1'b1;
        rsp_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.request_key = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_sent = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    phase_caps = '{64, 1, 0, 127, 5, 100, 0, 33};
    phase_caps[6] = $urandom_range(2, 63);
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // A heavily used entry must outlive fresh ones when the store of two is full.
    write_capacity(2);
    repeat (HOT_HITS) send_request(32'h1234_5678);
    send_request(32'h0BAD_F00D);
    send_request(32'h0000_0C0C);
    send_request(32'h1234_5678);
    send_request(32'h0BAD_F00D);

    write_capacity(64);
    send_request(32'h8000_0000);
    send_request(32'h7FFF_FFFF);
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0001);
    send_request(32'h5555_5555);
    send_request(32'hAAAA_AAAA);
    send_request(32'h8000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h7FFF_FFFF);
    send_request(32'h1234_5678);

    // Capacity below the current occupancy: each miss replaces one entry.
    write_capacity(3);
    send_request(32'h0000_0100);
    send_request(32'h0000_0200);
    send_request(32'h0000_0000);
    send_request(32'h0000_0300);

    write_capacity(0);
    send_request(32'hDEAD_0001);
    send_request(32'hDEAD_0002);
    send_request(32'hDEAD_0001);

    write_capacity(127);
    send_request(32'h8000_0001);
    send_request(32'h7FFF_FFFE);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_capacity(lfu_pkg::CAP_W'(phase_caps[phase]));
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 58;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_key());
        random_sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("lfu_cache_policy_test: clean");
    end else begin
      $display("lfu_cache_policy_test: errors");
    end
    $finish;
  end

endmodule
